// ===== src/pv2_pkg.sv =====
package pv2_pkg;

   typedef enum logic [3:0] {
      PH_START,
      PH_V2MAGIC,
      PH_V1MAGIC,
      PH_VERCMD,
      PH_FAMPROTO,
      PH_LEN,
      PH_ADDR,
      PH_TTYPE,
      PH_TLEN1,
      PH_TLEN2,
      PH_TVAL,
      PH_SKIP,
      PH_IDLE
   } phase_type;

   localparam logic [3:0] ST_DONE        = 4'd0;
   localparam logic [3:0] ST_TLV_BYTE    = 4'd1;
   localparam logic [3:0] ST_TLV_LAST    = 4'd2;
   localparam logic [3:0] ST_TLV_EMPTY   = 4'd3;
   localparam logic [3:0] ST_V1_SEEN     = 4'd4;
   localparam logic [3:0] ST_BAD_MAGIC   = 4'd5;
   localparam logic [3:0] ST_BAD_VERSION = 4'd6;
   localparam logic [3:0] ST_BAD_COMMAND = 4'd7;
   localparam logic [3:0] ST_BAD_FAMILY  = 4'd8;
   localparam logic [3:0] ST_BAD_PROTO   = 4'd9;
   localparam logic [3:0] ST_SHORT_BLOCK = 4'd10;

   localparam logic [1:0] FAM_UNSPEC = 2'd0;
   localparam logic [1:0] FAM_INET   = 2'd1;
   localparam logic [1:0] FAM_INET6  = 2'd2;
   localparam logic [1:0] FAM_UNIX   = 2'd3;

   localparam logic [1:0] TR_UNSPEC  = 2'd0;

   localparam logic [3:0] VERSION_2  = 4'd2;

   localparam logic [15:0] V2_MAGIC_LEN = 16'd12;
   localparam logic [15:0] V1_MAGIC_LEN = 16'd5;

   localparam logic [7:0] NEED_INET  = 8'd12;
   localparam logic [7:0] NEED_INET6 = 8'd36;
   localparam logic [7:0] NEED_UNIX  = 8'd216;

   localparam logic [15:0] ADDR_END_INET  = 16'd11;
   localparam logic [15:0] ADDR_END_INET6 = 16'd35;

   typedef struct packed {
      logic [3:0]  status;
      logic        command;
      logic [1:0]  address_family;
      logic [1:0]  transport;
      logic [63:0] saddr_hi;
      logic [63:0] saddr_lo;
      logic [63:0] daddr_hi;
      logic [63:0] daddr_lo;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  tlv_type;
      logic [7:0]  tlv_data;
   } rsp_type;

   function automatic logic [7:0] v2_magic_byte(input logic [3:0] idx);
      logic [7:0] val;
      case (idx)
         4'd0:    val = 8'h0D;
         4'd1:    val = 8'h0A;
         4'd2:    val = 8'h0D;
         4'd3:    val = 8'h0A;
         4'd4:    val = 8'h00;
         4'd5:    val = 8'h0D;
         4'd6:    val = 8'h0A;
         4'd7:    val = 8'h51;
         4'd8:    val = 8'h55;
         4'd9:    val = 8'h49;
         4'd10:   val = 8'h54;
         4'd11:   val = 8'h0A;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   function automatic logic [7:0] v1_magic_byte(input logic [2:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0:    val = 8'h50;
         3'd1:    val = 8'h52;
         3'd2:    val = 8'h4F;
         3'd3:    val = 8'h58;
         3'd4:    val = 8'h59;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// ===== src/pv2_parse.sv =====
module pv2_parse (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       byte_value,
   input  logic             start_of_stream,
   output logic             emit,
   output pv2_pkg::rsp_type result
);
   import pv2_pkg::*;

   phase_type   phase_ff, phase_in, eff_phase;
   logic [15:0] count_ff, count_in, eff_count;
   logic [15:0] blen_ff, blen_in, eff_blen;
   logic [4:0]  hdr_ff, hdr_in, eff_hdr;
   logic [63:0] src_hi_ff, src_hi_in, eff_src_hi;
   logic [63:0] src_lo_ff, src_lo_in, eff_src_lo;
   logic [63:0] dst_hi_ff, dst_hi_in, eff_dst_hi;
   logic [63:0] dst_lo_ff, dst_lo_in, eff_dst_lo;
   logic [31:0] ports_ff, ports_in, eff_ports;
   logic [7:0]  ttype_ff, ttype_in, eff_ttype;
   logic [15:0] trem_ff, trem_in, eff_trem;

   logic [15:0] count_inc;
   logic        last;
   logic        v2_hit, v1_hit;
   logic        ver_ok, cmd_ok, fam_ok, tr_ok;
   logic [15:0] blen_full;
   logic        skip_all, fam6, too_short;
   logic [7:0]  need;
   logic        addr_end;
   logic [15:0] trem_full, trem_dec;
   logic [16:0] room;
   logic        tlv_over;

   logic [3:0]  status;
   logic [7:0]  out_ttype, out_tdata;

   assign eff_phase  = start_of_stream ? PH_START : phase_ff;
   assign eff_count  = start_of_stream ? '0 : count_ff;
   assign eff_blen   = start_of_stream ? '0 : blen_ff;
   assign eff_hdr    = start_of_stream ? '0 : hdr_ff;
   assign eff_src_hi = start_of_stream ? '0 : src_hi_ff;
   assign eff_src_lo = start_of_stream ? '0 : src_lo_ff;
   assign eff_dst_hi = start_of_stream ? '0 : dst_hi_ff;
   assign eff_dst_lo = start_of_stream ? '0 : dst_lo_ff;
   assign eff_ports  = start_of_stream ? '0 : ports_ff;
   assign eff_ttype  = start_of_stream ? '0 : ttype_ff;
   assign eff_trem   = start_of_stream ? '0 : trem_ff;

   assign count_inc = eff_count + 16'd1;
   assign last      = (count_inc == eff_blen);

   assign v2_hit = (eff_count < V2_MAGIC_LEN) && (byte_value == v2_magic_byte(eff_count[3:0]));
   assign v1_hit = (eff_count < V1_MAGIC_LEN) && (byte_value == v1_magic_byte(eff_count[2:0]));

   assign ver_ok = (byte_value[7:4] == VERSION_2);
   assign cmd_ok = (byte_value[3:0] <= 4'd1);
   assign fam_ok = (byte_value[7:4] <= 4'd3);
   assign tr_ok  = (byte_value[3:0] <= 4'd2);

   assign blen_full = {eff_blen[15:8], byte_value};
   assign skip_all  = (eff_hdr[3:2] == FAM_UNSPEC) || (eff_hdr[1:0] == TR_UNSPEC);
   assign fam6      = (eff_hdr[3:2] == FAM_INET6);
   assign need      = (eff_hdr[3:2] == FAM_UNIX) ? NEED_UNIX : (fam6 ? NEED_INET6 : NEED_INET);
   assign too_short = (blen_full < {8'd0, need});
   assign addr_end  = (eff_count == (fam6 ? ADDR_END_INET6 : ADDR_END_INET));

   assign trem_full = {eff_trem[15:8], byte_value};
   assign trem_dec  = eff_trem - 16'd1;
   assign room      = {1'b0, eff_blen} - {1'b0, count_inc};
   assign tlv_over  = !room[16] && (trem_full > room[15:0]);

   always_comb begin
      phase_in  = eff_phase;
      count_in  = eff_count;
      blen_in   = eff_blen;
      hdr_in    = eff_hdr;
      src_hi_in = eff_src_hi;
      src_lo_in = eff_src_lo;
      dst_hi_in = eff_dst_hi;
      dst_lo_in = eff_dst_lo;
      ports_in  = eff_ports;
      ttype_in  = eff_ttype;
      trem_in   = eff_trem;
      case (eff_phase)
         PH_START: begin
            if (byte_value == v2_magic_byte(4'd0)) begin
               phase_in = PH_V2MAGIC;
               count_in = 16'd1;
            end else if (byte_value == v1_magic_byte(3'd0)) begin
               phase_in = PH_V1MAGIC;
               count_in = 16'd1;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_V2MAGIC: begin
            if (!v2_hit) begin
               phase_in = PH_IDLE;
            end else if (count_inc == V2_MAGIC_LEN) begin
               count_in = '0;
               phase_in = PH_VERCMD;
            end else begin
               count_in = count_inc;
            end
         end
         PH_V1MAGIC: begin
            if (!v1_hit) begin
               phase_in = PH_IDLE;
            end else begin
               count_in = count_inc;
               if (count_inc == V1_MAGIC_LEN) begin
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_VERCMD: begin
            if (!ver_ok || !cmd_ok) begin
               phase_in = PH_IDLE;
            end else begin
               hdr_in   = {byte_value[0], 4'd0};
               phase_in = PH_FAMPROTO;
            end
         end
         PH_FAMPROTO: begin
            if (!fam_ok || !tr_ok) begin
               phase_in = PH_IDLE;
            end else begin
               hdr_in   = {eff_hdr[4], byte_value[5:4], byte_value[1:0]};
               phase_in = PH_LEN;
               count_in = '0;
            end
         end
         PH_LEN: begin
            if (eff_count == 16'd0) begin
               blen_in  = {byte_value, 8'd0};
               count_in = 16'd1;
            end else begin
               blen_in  = blen_full;
               count_in = '0;
               if (skip_all) begin
                  phase_in = (blen_full == 16'd0) ? PH_IDLE : PH_SKIP;
               end else if (too_short) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = (eff_hdr[3:2] == FAM_UNIX) ? PH_SKIP : PH_ADDR;
               end
            end
         end
         PH_ADDR: begin
            count_in = count_inc;
            if (fam6) begin
               if (eff_count < 16'd8) begin
                  src_hi_in = {eff_src_hi[55:0], byte_value};
               end else if (eff_count < 16'd16) begin
                  src_lo_in = {eff_src_lo[55:0], byte_value};
               end else if (eff_count < 16'd24) begin
                  dst_hi_in = {eff_dst_hi[55:0], byte_value};
               end else if (eff_count < 16'd32) begin
                  dst_lo_in = {eff_dst_lo[55:0], byte_value};
               end else begin
                  ports_in = {eff_ports[23:0], byte_value};
               end
            end else begin
               if (eff_count < 16'd4) begin
                  src_lo_in = {eff_src_lo[55:0], byte_value};
               end else if (eff_count < 16'd8) begin
                  dst_lo_in = {eff_dst_lo[55:0], byte_value};
               end else begin
                  ports_in = {eff_ports[23:0], byte_value};
               end
            end
            if (addr_end) begin
               if (last) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = eff_hdr[4] ? PH_TTYPE : PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            count_in = count_inc;
            if (last) begin
               phase_in = PH_IDLE;
            end
         end
         PH_TTYPE: begin
            count_in = count_inc;
            ttype_in = byte_value;
            phase_in = last ? PH_IDLE : PH_TLEN1;
         end
         PH_TLEN1: begin
            count_in = count_inc;
            trem_in  = {byte_value, 8'd0};
            phase_in = last ? PH_IDLE : PH_TLEN2;
         end
         PH_TLEN2: begin
            count_in = count_inc;
            trem_in  = trem_full;
            if (tlv_over) begin
               phase_in = PH_IDLE;
            end else if (trem_full == 16'd0) begin
               phase_in = last ? PH_IDLE : PH_TTYPE;
            end else begin
               phase_in = PH_TVAL;
            end
         end
         PH_TVAL: begin
            count_in = count_inc;
            trem_in  = trem_dec;
            if (trem_dec == 16'd0) begin
               phase_in = last ? PH_IDLE : PH_TTYPE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      emit      = 1'b0;
      status    = ST_DONE;
      out_ttype = '0;
      out_tdata = '0;
      case (eff_phase)
         PH_START: begin
            if (byte_value != v2_magic_byte(4'd0) && byte_value != v1_magic_byte(3'd0)) begin
               emit   = 1'b1;
               status = ST_BAD_MAGIC;
            end
         end
         PH_V2MAGIC: begin
            if (!v2_hit) begin
               emit   = 1'b1;
               status = ST_BAD_MAGIC;
            end
         end
         PH_V1MAGIC: begin
            if (!v1_hit) begin
               emit   = 1'b1;
               status = ST_BAD_MAGIC;
            end else if (count_inc == V1_MAGIC_LEN) begin
               emit   = 1'b1;
               status = ST_V1_SEEN;
            end
         end
         PH_VERCMD: begin
            if (!ver_ok) begin
               emit   = 1'b1;
               status = ST_BAD_VERSION;
            end else if (!cmd_ok) begin
               emit   = 1'b1;
               status = ST_BAD_COMMAND;
            end
         end
         PH_FAMPROTO: begin
            if (!fam_ok) begin
               emit   = 1'b1;
               status = ST_BAD_FAMILY;
            end else if (!tr_ok) begin
               emit   = 1'b1;
               status = ST_BAD_PROTO;
            end
         end
         PH_LEN: begin
            if (eff_count != 16'd0) begin
               if (skip_all) begin
                  emit   = (blen_full == 16'd0);
                  status = ST_DONE;
               end else if (too_short) begin
                  emit   = 1'b1;
                  status = ST_SHORT_BLOCK;
               end
            end
         end
         PH_ADDR: begin
            emit   = addr_end && last;
            status = ST_DONE;
         end
         PH_SKIP: begin
            emit   = last;
            status = ST_DONE;
         end
         PH_TTYPE, PH_TLEN1: begin
            emit   = last;
            status = ST_SHORT_BLOCK;
         end
         PH_TLEN2: begin
            if (tlv_over) begin
               emit   = 1'b1;
               status = ST_SHORT_BLOCK;
            end else if (trem_full == 16'd0) begin
               emit      = 1'b1;
               status    = last ? ST_DONE : ST_TLV_EMPTY;
               out_ttype = eff_ttype;
            end
         end
         PH_TVAL: begin
            emit      = 1'b1;
            out_ttype = eff_ttype;
            out_tdata = byte_value;
            if (trem_dec == 16'd0) begin
               status = last ? ST_DONE : ST_TLV_LAST;
            end else begin
               status = ST_TLV_BYTE;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      result.status         = status;
      result.command        = hdr_in[4];
      result.address_family = hdr_in[3:2];
      result.transport      = hdr_in[1:0];
      result.saddr_hi       = src_hi_in;
      result.saddr_lo       = src_lo_in;
      result.daddr_hi       = dst_hi_in;
      result.daddr_lo       = dst_lo_in;
      result.sport          = ports_in[31:16];
      result.dport          = ports_in[15:0];
      result.tlv_type       = out_ttype;
      result.tlv_data       = out_tdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         count_ff  <= '0;
         blen_ff   <= '0;
         hdr_ff    <= '0;
         src_hi_ff <= '0;
         src_lo_ff <= '0;
         dst_hi_ff <= '0;
         dst_lo_ff <= '0;
         ports_ff  <= '0;
         ttype_ff  <= '0;
         trem_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         blen_ff   <= blen_in;
         hdr_ff    <= hdr_in;
         src_hi_ff <= src_hi_in;
         src_lo_ff <= src_lo_in;
         dst_hi_ff <= dst_hi_in;
         dst_lo_ff <= dst_lo_in;
         ports_ff  <= ports_in;
         ttype_ff  <= ttype_in;
         trem_ff   <= trem_in;
      end
   end

endmodule

// ===== src/proxy_v2_binary_header_parser.sv =====
// Channel   Direction  Fields                                              Beat when
// req_      in         byte_value, start_of_stream                         req_valid & req_ready
// rsp_      out        status, command, address_family, transport,         rsp_valid & rsp_ready
//                      source/dest addr hi/lo, source/dest port, tlv_type, tlv_data
//
// One byte per cycle unless a held result stalls; results come from the result register.
// The path runs input register -> parser state update -> result register.
// reset clears the parser to wait for magic and empties both registers.
// A held result stalls the parser; the input register still takes one more beat.
module proxy_v2_binary_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_value,
   input  logic        req_start_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_status,
   output logic        rsp_command,
   output logic [1:0]  rsp_address_family,
   output logic [1:0]  rsp_transport,
   output logic [63:0] rsp_saddr_hi,
   output logic [63:0] rsp_saddr_lo,
   output logic [63:0] rsp_daddr_hi,
   output logic [63:0] rsp_daddr_lo,
   output logic [15:0] rsp_sport,
   output logic [15:0] rsp_dport,
   output logic [7:0]  rsp_tlv_type,
   output logic [7:0]  rsp_tlv_data
);
   import pv2_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_sos_ff;
   logic       step;
   logic       emit;
   rsp_type    result;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;

   assign step        = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || step;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !step);
   assign out_valid_in = (out_valid_ff && !rsp_ready) || (step && emit);

   pv2_parse u_parse (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .byte_value      (in_byte_ff),
      .start_of_stream (in_sos_ff),
      .emit            (emit),
      .result          (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_byte_value;
         in_sos_ff  <= req_start_of_stream;
      end
      if (step && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_ff.status;
   assign rsp_command        = out_ff.command;
   assign rsp_address_family = out_ff.address_family;
   assign rsp_transport      = out_ff.transport;
   assign rsp_saddr_hi       = out_ff.saddr_hi;
   assign rsp_saddr_lo       = out_ff.saddr_lo;
   assign rsp_daddr_hi       = out_ff.daddr_hi;
   assign rsp_daddr_lo       = out_ff.daddr_lo;
   assign rsp_sport          = out_ff.sport;
   assign rsp_dport          = out_ff.dport;
   assign rsp_tlv_type       = out_ff.tlv_type;
   assign rsp_tlv_data       = out_ff.tlv_data;

endmodule

// ===== src/pv2_checker.sv =====
module pv2_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_status,
   input logic [1:0]  rsp_address_family,
   input logic [63:0] rsp_saddr_hi,
   input logic [63:0] rsp_daddr_hi,
   input logic [7:0]  rsp_tlv_type,
   input logic [7:0]  rsp_tlv_data
);
   import pv2_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_tlv_data))
      else $error("result changed while stalled");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_SHORT_BLOCK)
      else $error("status code out of range");

   a_error_no_tlv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status >= ST_V1_SEEN |-> rsp_tlv_type == 8'd0 && rsp_tlv_data == 8'd0)
      else $error("tlv fields set on a final status");

   a_empty_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_TLV_EMPTY |-> rsp_tlv_data == 8'd0)
      else $error("data on empty tlv");

   a_hi_only_inet6: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_address_family != FAM_INET6
         |-> rsp_saddr_hi == 64'd0 && rsp_daddr_hi == 64'd0)
      else $error("upper address half set outside IPv6");

endmodule

bind proxy_v2_binary_header_parser pv2_checker u_pv2_checker (.*);
